// ----- src/fully_assoc_lru_cache_tags_unit_assert.svh -----
// Assertion macros shared by the cache tag unit.
`ifndef FULLY_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH
`define FULLY_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define FALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("falc: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define FALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("falc: next-cycle check failed");

`else

`define FALC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FALC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/falc_pkg.sv -----
// Shared types and constants of the fully associative LRU cache tag unit.
package falc_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int OFFSET_W   = 5;
    localparam int LINES_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 2'd2;

    localparam logic                RST_WRITE_MODE   = 1'b0;
    localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS  = 5'd4;
    localparam logic [LINES_W-1:0]  RST_LINES_IN_USE = 7'd64;

    localparam logic MODE_WRITE_BACK = 1'b0;
    localparam logic CMD_WRITE       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctl_cmd;

endpackage

// ----- src/falc_ctrl.sv -----
// Controller: sequences one transaction through load, search and update.
module falc_ctrl #(
    parameter int MAX_LINES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output logic                o_valid,
    output falc_pkg::t_ctl_cmd  o_ctl
);
    import falc_pkg::*;

    localparam int LEVELS = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W  = $clog2(LEVELS + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= o_ctl.commit;
        end
    end

    // The search state waits for the registered minimum tree to settle, one
    // level per cycle, before the update may use its root.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_SEARCH;
                    n_cnt      = CNT_W'(LEVELS - 1);
                end
            end
            ST_SEARCH: begin
                if (r_cnt == '0) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_UPDATE: begin
                o_ctl.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- src/falc_dpath.sv -----
// Datapath: line state, parallel tag compare, registered LRU minimum tree.
module falc_dpath #(
    parameter int MAX_LINES  = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  falc_pkg::t_ctl_cmd                 i_ctl,
    input  logic                               i_cmd,
    input  logic [falc_pkg::ADDR_W-1:0]        i_address,
    input  logic                               i_cfg_we,
    input  logic [falc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [falc_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_hit
);
    import falc_pkg::*;

    localparam int LEVELS = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LEAVES = 1 << LEVELS;
    localparam int IDX_W  = LEVELS;

    // Configuration registers.
    logic                r_write_mode;
    logic [OFFSET_W-1:0] r_offset_bits;
    logic [LINES_W-1:0]  r_lines;

    // Transaction held for the duration of the search.
    logic                  r_cmd;
    logic [ADDR_W-1:0]     r_tag;
    logic [STAMP_BITS-1:0] r_count;
    logic                  r_hit;

    // Line state.
    logic [MAX_LINES-1:0]  r_valid;
    logic [MAX_LINES-1:0]  r_dirty;
    logic [ADDR_W-1:0]     r_line_tag [MAX_LINES];
    logic [STAMP_BITS-1:0] r_stamp    [MAX_LINES];
    logic [MAX_LINES-1:0]  r_match;

    // Tree nodes: indices 1 to LEAVES-1 are registered, the rest are leaves.
    logic                  w_ok    [1:2*LEAVES-1];
    logic [STAMP_BITS-1:0] w_stamp [1:2*LEAVES-1];
    logic [IDX_W-1:0]      w_idx   [1:2*LEAVES-1];
    logic                  r_nd_ok    [1:LEAVES-1];
    logic [STAMP_BITS-1:0] r_nd_stamp [1:LEAVES-1];
    logic [IDX_W-1:0]      r_nd_idx   [1:LEAVES-1];

    logic             w_any_hit;
    logic [IDX_W-1:0] w_hit_idx;
    logic [IDX_W-1:0] w_victim;
    logic [IDX_W-1:0] w_sel;
    logic             w_victim_dirty;
    logic             w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_mode  <= RST_WRITE_MODE;
            r_offset_bits <= RST_OFFSET_BITS;
            r_lines       <= RST_LINES_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRITE_MODE:   r_write_mode  <= i_cfg_data[0];
                CFG_OFFSET_BITS:  r_offset_bits <= i_cfg_data[OFFSET_W-1:0];
                CFG_LINES_IN_USE: r_lines       <= i_cfg_data[LINES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.load) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_tag <= i_address >> r_offset_bits;
        end
    end

    // Leaves: a line takes part when it lies below the line count; line zero
    // always does, so a count of zero behaves as one line.
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < MAX_LINES) begin : g_real
            assign w_ok[LEAVES+j]    = (j == 0) || (32'(j) < 32'(r_lines));
            assign w_stamp[LEAVES+j] = r_stamp[j];
        end else begin : g_pad
            assign w_ok[LEAVES+j]    = 1'b0;
            assign w_stamp[LEAVES+j] = '0;
        end
        assign w_idx[LEAVES+j] = IDX_W'(j);
    end

    // Each node keeps the smaller stamp of its children; on a tie the left,
    // lower-indexed child wins.
    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        logic take_l;
        assign take_l = w_ok[2*k] &&
                        (!w_ok[2*k+1] || (w_stamp[2*k] <= w_stamp[2*k+1]));
        always_ff @(posedge i_clk) begin
            r_nd_ok[k]    <= w_ok[2*k] || w_ok[2*k+1];
            r_nd_stamp[k] <= take_l ? w_stamp[2*k] : w_stamp[2*k+1];
            r_nd_idx[k]   <= take_l ? w_idx[2*k]   : w_idx[2*k+1];
        end
        assign w_ok[k]    = r_nd_ok[k];
        assign w_stamp[k] = r_nd_stamp[k];
        assign w_idx[k]   = r_nd_idx[k];
    end

    for (genvar i = 0; i < MAX_LINES; i++) begin : g_cmp
        always_ff @(posedge i_clk) begin
            r_match[i] <= r_valid[i] && w_ok[LEAVES+i] && (r_line_tag[i] == r_tag);
        end
    end

    // The lowest matching line is the one that hits.
    always_comb begin
        w_hit_idx = '0;
        for (int i = MAX_LINES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    assign w_any_hit      = |r_match;
    assign w_victim       = r_nd_idx[1];
    assign w_sel          = w_any_hit ? w_hit_idx : w_victim;
    assign w_victim_dirty = r_dirty[w_victim];

    always_comb begin
        if (w_any_hit) begin
            w_res = (r_write_mode == MODE_WRITE_BACK) ? 1'b1 : (r_cmd != CMD_WRITE);
        end else begin
            w_res = (r_write_mode == MODE_WRITE_BACK) && (r_cmd == CMD_WRITE) &&
                    !w_victim_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            for (int i = 0; i < MAX_LINES; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (i_ctl.commit) begin
            r_valid[w_sel] <= 1'b1;
            r_stamp[w_sel] <= r_count;
            if (r_write_mode == MODE_WRITE_BACK) begin
                if (!w_any_hit) begin
                    r_dirty[w_sel] <= (r_cmd == CMD_WRITE);
                end else if (r_cmd == CMD_WRITE) begin
                    r_dirty[w_sel] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_hit <= w_res;
            if (!w_any_hit) begin
                r_line_tag[w_sel] <= r_tag;
            end
        end
    end

    assign o_hit = r_hit;

endmodule

// ----- src/fully_assoc_lru_cache_tags_unit.sv -----
// Top level of the fully associative LRU cache tag unit.
//
//  Channel   Handshake                Payload
//  access    start / busy             i_cmd, i_address
//  result    o_valid (strobe)         o_hit
//  config    i_cfg_we                 i_cfg_idx, i_cfg_data
//
// A transaction passes from acceptance through the search state, where the controller
// waits for the registered minimum-stamp tree to settle, one tree level per cycle,
// to the update state and then the result strobe. busy is high in the search and
// update states and low again while the result is shown, so the next access may
// be accepted in the cycle the result is shown. Reset is synchronous and clears
// line state at once; the result strobe lasts one cycle and cannot be held off.
`include "fully_assoc_lru_cache_tags_unit_assert.svh"

module fully_assoc_lru_cache_tags_unit #(
    parameter int MAX_LINES  = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [falc_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_valid,
    output logic                               o_hit,
    input  logic                               i_cfg_we,
    input  logic [falc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [falc_pkg::CFG_W-1:0]         i_cfg_data
);
    import falc_pkg::*;

    t_ctl_cmd w_ctl;

    falc_ctrl #(
        .MAX_LINES (MAX_LINES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    falc_dpath #(
        .MAX_LINES  (MAX_LINES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cmd      (i_cmd),
        .i_address  (i_address),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_hit      (o_hit)
    );

    // An accepted transaction keeps the unit busy in the following cycle.
    `FALC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // Line state is only updated while a transaction is in flight.
    `FALC_ASSERT_IMP(a_commit_busy, i_clk, i_rst_n, w_ctl.commit, busy)
    // The result strobe follows the update cycle and never repeats at once.
    `FALC_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_valid, !o_valid)
    `FALC_ASSERT_IMP(a_result_after_commit, i_clk, i_rst_n, o_valid, $past(w_ctl.commit))

endmodule

// ----- tb/tb_fully_assoc_lru_cache_tags_unit.sv -----
// Self-checking testbench for the fully associative LRU cache tag unit.
`timescale 1ns / 1ps

class lru_tag_tracker;

    int          max_lines;

    logic        write_mode;
    logic [4:0]  shift;
    logic [6:0]  lines_reg;

    bit          valid [];
    bit          dirty [];
    bit [31:0]   tag_of [];
    bit [31:0]   stamp [];
    bit [31:0]   access_count;

    bit          want_hits [$];
    int          errors;

    function new(int lines);
        max_lines    = lines;
        write_mode   = falc_pkg::RST_WRITE_MODE;
        shift        = falc_pkg::RST_OFFSET_BITS;
        lines_reg    = falc_pkg::RST_LINES_IN_USE;
        access_count = '0;
        errors       = 0;
        valid        = new[lines];
        dirty        = new[lines];
        tag_of       = new[lines];
        stamp        = new[lines];
        for (int i = 0; i < lines; i++) begin
            valid[i]  = 1'b0;
            dirty[i]  = 1'b0;
            tag_of[i] = '0;
            stamp[i]  = '0;
        end
    endfunction

    function void set_reg(logic [falc_pkg::CFG_IDX_W-1:0] idx, logic [falc_pkg::CFG_W-1:0] data);
        case (idx)
            falc_pkg::CFG_WRITE_MODE:   write_mode = data[0];
            falc_pkg::CFG_OFFSET_BITS:  shift      = data[4:0];
            falc_pkg::CFG_LINES_IN_USE: lines_reg  = data[6:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return want_hits.size();
    endfunction

    // Works out the reported hit for one accepted lookup and updates the line state.
    function void note_access(logic cmd, logic [31:0] addr);
        bit        is_write;
        bit        wb_policy;
        bit [31:0] tag_v;
        int        n;
        int        found;
        int        victim;
        bit        was_dirty;
        bit        res;

        is_write   = (cmd == falc_pkg::CMD_WRITE);
        wb_policy  = (write_mode == falc_pkg::MODE_WRITE_BACK);
        tag_v      = addr >> shift;
        n          = (lines_reg == 0) ? 1
                   : ((int'(lines_reg) > max_lines) ? max_lines : int'(lines_reg));
        found      = -1;
        access_count = access_count + 32'd1;

        for (int i = 0; i < n; i++) begin
            if (found < 0 && valid[i] && tag_of[i] == tag_v) found = i;
        end

        if (found >= 0) begin
            stamp[found] = access_count;
            if (wb_policy) begin
                if (is_write) dirty[found] = 1'b1;
                res = 1'b1;
            end else begin
                res = !is_write;
            end
        end else begin
            // Oldest stamp loses; a strict compare keeps the lowest index on ties.
            victim = 0;
            for (int i = 1; i < n; i++) begin
                if (stamp[i] < stamp[victim]) victim = i;
            end
            was_dirty      = dirty[victim];
            valid[victim]  = 1'b1;
            tag_of[victim] = tag_v;
            stamp[victim]  = access_count;
            if (wb_policy) begin
                if (is_write) begin
                    dirty[victim] = 1'b1;
                    res = !was_dirty;
                end else begin
                    dirty[victim] = 1'b0;
                    res = 1'b0;
                end
            end else begin
                res = 1'b0;
            end
        end
        want_hits.push_back(res);
    endfunction

    function void check_hit(logic got);
        bit want;

        if (want_hits.size() == 0) begin
            $display("%0t: result with no transaction outstanding, expected none, actual hit=%0b",
                     $time, got);
            errors++;
        end else begin
            want = want_hits.pop_front();
            if (got !== want) begin
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, got);
                errors++;
            end
        end
    endfunction

endclass

module tb_fully_assoc_lru_cache_tags_unit;

    import falc_pkg::*;

    localparam int   TB_LINES  = 64;
    localparam logic CMD_READ  = ~CMD_WRITE;
    localparam logic MODE_WRITE_THROUGH = ~MODE_WRITE_BACK;
    localparam int   POOL_MAX  = 96;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  i_cmd     = 1'b0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic                  i_cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    lru_tag_tracker tracker;

    logic [31:0] tag_pool [POOL_MAX];
    int          pool_size;
    logic [4:0]  cur_shift;

    fully_assoc_lru_cache_tags_unit #(
        .MAX_LINES  (TB_LINES),
        .STAMP_BITS (32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_address  (i_address),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) tracker.check_hit(o_hit);
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_lookup(input logic cmd, input logic [31:0] addr);
        @(negedge i_clk);
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_access(cmd, addr);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Lets every outstanding transaction finish, plus the pipeline depth for margin.
    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(idx, data);
        if (idx == CFG_OFFSET_BITS) cur_shift = data[4:0];
    endtask

    function automatic logic [31:0] pick_address();
        logic [31:0] low_mask;
        logic [31:0] t;

        low_mask = (32'd1 << cur_shift) - 32'd1;
        if ($urandom_range(0, 99) < 15) return $urandom;
        t = tag_pool[$urandom_range(0, pool_size - 1)];
        return (t << cur_shift) | ($urandom & low_mask);
    endfunction

    initial begin : stimulus
        int         idle_pct;
        int         n_lines;
        logic       mode_v;
        logic [4:0] shift_v;
        logic [6:0] lines_v;

        tracker   = new(TB_LINES);
        cur_shift = RST_OFFSET_BITS;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: write-back, 16-byte blocks, all lines.
        send_lookup(CMD_READ,  32'h0000_0000);
        send_lookup(CMD_WRITE, 32'h0000_000F);
        send_lookup(CMD_READ,  32'hFFFF_FFFF);
        send_lookup(CMD_WRITE, 32'hFFFF_FFF0);
        send_lookup(CMD_WRITE, 32'h1234_5678);

        // A single line makes every miss evict line zero, dirty or clean.
        wait_for_results();
        program_reg(CFG_LINES_IN_USE, 7'd1);
        send_lookup(CMD_WRITE, 32'hA000_0000);
        send_lookup(CMD_READ,  32'hB000_0000);
        send_lookup(CMD_WRITE, 32'hC000_0000);
        send_lookup(CMD_READ,  32'hC000_0004);

        // A line count of zero behaves as one line.
        wait_for_results();
        program_reg(CFG_LINES_IN_USE, 7'd0);
        send_lookup(CMD_READ,  32'hC000_0008);
        send_lookup(CMD_READ,  32'h0000_0000);

        // Lines left out of use come back with their old tags; then write-through.
        wait_for_results();
        program_reg(CFG_LINES_IN_USE, 7'd64);
        program_reg(CFG_WRITE_MODE, 7'(MODE_WRITE_THROUGH));
        send_lookup(CMD_READ,  32'hFFFF_FFF8);
        send_lookup(CMD_WRITE, 32'h1234_5670);
        send_lookup(CMD_WRITE, 32'h5555_5555);

        // Largest shift leaves a one-bit tag; line count beyond the array saturates.
        wait_for_results();
        program_reg(CFG_OFFSET_BITS, 7'd31);
        program_reg(CFG_LINES_IN_USE, 7'd127);
        program_reg(CFG_WRITE_MODE, 7'(MODE_WRITE_BACK));
        send_lookup(CMD_READ,  32'h8000_0000);
        send_lookup(CMD_READ,  32'hFFFF_FFFF);
        send_lookup(CMD_WRITE, 32'h7FFF_FFFF);

        wait_for_results();
        program_reg(CFG_OFFSET_BITS, 7'd0);
        send_lookup(CMD_READ,  32'hAAAA_AAAA);
        send_lookup(CMD_READ,  32'hAAAA_AAAB);

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin mode_v = MODE_WRITE_BACK;    shift_v = 5'd4;  lines_v = 7'd64;  end
                1: begin mode_v = MODE_WRITE_THROUGH; shift_v = 5'd0;  lines_v = 7'd1;   end
                2: begin mode_v = MODE_WRITE_BACK;    shift_v = 5'd16; lines_v = 7'd127; end
                3: begin mode_v = MODE_WRITE_BACK;    shift_v = 5'd31; lines_v = 7'd0;   end
                4: begin mode_v = MODE_WRITE_BACK;    shift_v = 5'd2;  lines_v = 7'd8;   end
                default: begin
                    mode_v  = 1'($urandom_range(0, 1));
                    shift_v = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                          : 5'($urandom_range(0, 16));
                    lines_v = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(1, 16));
                end
            endcase

            wait_for_results();
            program_reg(CFG_WRITE_MODE, 7'(mode_v));
            program_reg(CFG_OFFSET_BITS, 7'(shift_v));
            program_reg(CFG_LINES_IN_USE, lines_v);

            // A pool a little larger than the cache keeps hits and evictions both common.
            n_lines = (lines_v == 0) ? 1 : ((lines_v > TB_LINES) ? TB_LINES : int'(lines_v));
            pool_size = n_lines + 1 + $urandom_range(0, n_lines / 2);
            if (pool_size > POOL_MAX) pool_size = POOL_MAX;
            for (int k = 0; k < pool_size; k++) tag_pool[k] = $urandom >> shift_v;

            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 50;
            endcase
            if (p == 9) idle_pct = 0;

            for (int k = 0; k < 200; k++) begin
                send_lookup(1'($urandom_range(0, 1)), pick_address());
                if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 13));
            end
        end

        wait_for_results();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/falc_pkg.sv
src/falc_ctrl.sv
src/falc_dpath.sv
src/fully_assoc_lru_cache_tags_unit.sv
tb/tb_fully_assoc_lru_cache_tags_unit.sv
